@@ hdl/kmd5_pkg.sv @@
// Shared types and constants for the keyed double MD5 block.
`timescale 1ns / 1ps
`default_nettype none
package kmd5_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       final_item;
	} in_item_t;

	typedef struct packed {
		logic [63:0] digest_half;
		logic        digest_valid;
		logic        last_half;
	} out_item_t;

	typedef struct packed {
		logic        go;
		logic        chain_init;
	} core_cmd_t;

	localparam logic [1:0] REG_KEY_READY = 2'd0;
	localparam logic [1:0] REG_KEY_UPPER = 2'd1;
	localparam logic [1:0] REG_KEY_LOWER = 2'd2;

	localparam logic [127:0] MD_INIT = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

	function automatic logic [31:0] md_k(input logic [5:0] i);
		logic [31:0] k;
		begin
			case (i)
			6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
			endcase
			return k;
		end
	endfunction

	function automatic logic [4:0] md_rot(input logic [5:0] i);
		logic [4:0] r;
		begin
			case ({i[5:4], i[1:0]})
			4'd0: r = 5'd7;  4'd1: r = 5'd12; 4'd2: r = 5'd17; 4'd3: r = 5'd22;
			4'd4: r = 5'd5;  4'd5: r = 5'd9;  4'd6: r = 5'd14; 4'd7: r = 5'd20;
			4'd8: r = 5'd4;  4'd9: r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
			4'd12: r = 5'd6; 4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
			endcase
			return r;
		end
	endfunction

	// message word index used by round i
	function automatic logic [3:0] md_g(input logic [5:0] i);
		logic [3:0] g;
		begin
			case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = 4'((i[3:0] * 4'd5) + 4'd1);
			2'd2: g = 4'((i[3:0] * 4'd3) + 4'd5);
			default: g = 4'(i[3:0] * 4'd7);
			endcase
			return g;
		end
	endfunction

endpackage
`default_nettype wire

@@ hdl/kmd5_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module kmd5_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ hdl/kmd5_round.sv @@
// MD5 compression engine: 64 rounds, one per cycle, words read from the block RAM.
`timescale 1ns / 1ps
`default_nettype none
module kmd5_round (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire kmd5_pkg::core_cmd_t   cmd,
	input  wire logic [31:0]           word,
	output logic      [3:0]            word_addr,
	output logic                       done,
	output logic      [127:0]          chain
);
	import kmd5_pkg::*;

	logic        run_q;
	logic        fin_q;
	logic [5:0]  rnd_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [127:0] chain_q;
	logic [31:0] f, t, rt;
	logic [4:0]  s;

	// word for round i is requested in the cycle before round i uses it
	assign word_addr = run_q ? md_g(6'(rnd_q + 6'd1)) : md_g(6'd0);

	always_comb begin
		unique case (rnd_q[5:4])
		2'd0: f = (b_q & c_q) | (~b_q & d_q);
		2'd1: f = (b_q & d_q) | (c_q & ~d_q);
		2'd2: f = b_q ^ c_q ^ d_q;
		default: f = c_q ^ (b_q | ~d_q);
		endcase
		t  = a_q + f + md_k(rnd_q) + word;
		s  = md_rot(rnd_q);
		rt = (t << s) | (t >> (6'd32 - {1'b0, s}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			fin_q   <= 1'b0;
			rnd_q   <= '0;
			chain_q <= MD_INIT;
		end else begin
			fin_q <= 1'b0;
			if (cmd.go) begin
				run_q <= 1'b1;
				rnd_q <= '0;
				if (cmd.chain_init) begin
					chain_q <= MD_INIT;
				end
			end else if (run_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					run_q   <= 1'b0;
					fin_q   <= 1'b1;
					chain_q <= {chain_q[127:96] + c_q, chain_q[95:64] + b_q,
						chain_q[63:32] + b_q + rt, chain_q[31:0] + d_q};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			a_q <= cmd.chain_init ? MD_INIT[31:0]   : chain_q[31:0];
			b_q <= cmd.chain_init ? MD_INIT[63:32]  : chain_q[63:32];
			c_q <= cmd.chain_init ? MD_INIT[95:64]  : chain_q[95:64];
			d_q <= cmd.chain_init ? MD_INIT[127:96] : chain_q[127:96];
		end else if (run_q) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + rt;
		end
	end

	assign done  = fin_q;
	assign chain = chain_q;
endmodule
`default_nettype wire

@@ hdl/keyed_md5_digest.sv @@
// Top level: byte absorber, padding sequencer and double MD5 over four byte-lane RAMs.
//   channel | signals                 | handshake
//   request | start, busy, in_item    | taken when start && !busy
//   result  | out_strobe, out_item    | one cycle per result, no stall
//   config  | cfg_we, cfg_index, cfg_data | written on any edge with cfg_we
// Non-final byte: stored alone, or, when it completes a 64-byte block, it starts
// a compression (64 rounds, the chain folded in with the last round; busy throughout).
// Final item: busy through up to three compressions, the padding writes ahead of
// the padded blocks and the result halves back to back.
// Reset loads the MD5 initial chain; the byte-lane RAMs need no clearing.
// busy stays high while compressing or emitting; results cannot be held off.
`timescale 1ns / 1ps
`default_nettype none
module keyed_md5_digest (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire kmd5_pkg::in_item_t   in_item,
	output logic                      out_strobe,
	output kmd5_pkg::out_item_t       out_item,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [63:0]          cfg_data
);
	import kmd5_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_OUT1 = 3'd3;
	localparam logic [2:0] ST_OUT2 = 3'd4;

	logic        key_ready_q;
	logic [63:0] key_upper_q, key_lower_q;
	logic [2:0]  st_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [5:0]  pad_q;
	logic        extra_q;   // a second padded block follows
	logic        pass2_q;   // working on the outer hash
	logic        final_q;   // compression belongs to message close
	logic        fresh_q;   // no block of this message compressed yet
	logic [127:0] digest_q;
	logic [63:0] half2_q;

	logic        ram_we;
	logic [5:0]  ram_wa;
	logic [7:0]  ram_wd;
	logic [3:0]  word_addr;
	logic [31:0] word;
	core_cmd_t   cmd;
	logic        done;
	logic [127:0] chain;
	logic        accept;
	logic [5:0]  pad_byte_pos;
	logic [7:0]  pad_val;
	logic [127:0] inner_x;
	logic [127:0] outer;

	// four byte lanes, one RAM each, so all four bytes of a 32-bit word read together
	genvar gl;
	generate
		for (gl = 0; gl < 4; gl++) begin : g_lane
			kmd5_ram #(.Width(8), .Depth(16)) u_ram (
				.clk  (clk),
				.we   (ram_we && (ram_wa[1:0] == 2'(gl))),
				.waddr(ram_wa[5:2]),
				.wdata(ram_wd),
				.raddr(word_addr),
				.rdata(word[8*gl +: 8])
			);
		end
	endgenerate

	kmd5_round u_round (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .word(word),
		.word_addr(word_addr), .done(done), .chain(chain)
	);

	assign accept = start && !busy;
	assign busy   = (st_q != ST_IDLE);

	// first digest xor byte-swapped key, as the 16-byte outer message
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			inner_x[8*i +: 8] = digest_q[8*i +: 8];
		end
		for (int i = 0; i < 8; i++) begin
			inner_x[8*i +: 8]     = digest_q[8*i +: 8] ^ key_upper_q[56-8*i +: 8];
			inner_x[64+8*i +: 8]  = digest_q[64+8*i +: 8] ^ key_lower_q[56-8*i +: 8];
		end
	end

	// padding byte at pad_q; pass 2 has fixed length 16
	always_comb begin
		pad_byte_pos = pad_q;
		if (pass2_q) begin
			if (pad_q < 6'd16) begin
				pad_val = inner_x[8*pad_q[3:0] +: 8];
			end else if (pad_q == 6'd16) begin
				pad_val = 8'h80;
			end else if (pad_q == 6'd57) begin
				pad_val = 8'h00;
			end else if (pad_q == 6'd56) begin
				pad_val = 8'h80;
			end else begin
				pad_val = 8'h00;
			end
		end else if (!extra_q && pad_q == fill_q) begin
			pad_val = 8'h80;
		end else if (pad_q >= 6'd56 && !(extra_q == 1'b0 && fill_q >= 6'd56)) begin
			pad_val = bits_q[8*pad_q[2:0] +: 8];
		end else begin
			pad_val = 8'h00;
		end
	end

	always_comb begin
		ram_we = 1'b0;
		ram_wa = pad_byte_pos;
		ram_wd = pad_val;
		cmd    = '0;
		if (accept && in_item.byte_present) begin
			ram_we = 1'b1;
			ram_wa = fill_q;
			ram_wd = in_item.data_byte;
		end else if (st_q == ST_PAD) begin
			ram_we = 1'b1;
		end
		if (st_q == ST_PAD && pad_q == 6'd63) begin
			cmd.go         = 1'b1;
			cmd.chain_init = pass2_q || fresh_q;
		end else if (accept && in_item.byte_present && fill_q == 6'd63) begin
			cmd.go         = 1'b1;
			cmd.chain_init = fresh_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_ready_q <= 1'b0;
			key_upper_q <= '0;
			key_lower_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
			REG_KEY_READY: key_ready_q <= cfg_data[0];
			REG_KEY_UPPER: key_upper_q <= cfg_data;
			REG_KEY_LOWER: key_lower_q <= cfg_data;
			default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			fill_q  <= '0;
			bits_q  <= '0;
			pad_q   <= '0;
			extra_q <= 1'b0;
			pass2_q <= 1'b0;
			final_q <= 1'b0;
			fresh_q <= 1'b1;
		end else begin
			unique case (st_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_item.byte_present) begin
						fill_q <= fill_q + 6'd1;
						bits_q <= bits_q + 64'd8;
					end
					if (in_item.final_item) begin
						// close: first padded block starts after any stored bytes
						pad_q   <= fill_q + 6'(in_item.byte_present);
						pass2_q <= 1'b0;
						if (in_item.byte_present && fill_q == 6'd63) begin
							// full block first, then a padding-only block
							st_q    <= ST_COMP;
							extra_q <= 1'b1;
							final_q <= 1'b0;
						end else begin
							st_q    <= ST_PAD;
							extra_q <= 1'b0;
							final_q <= 1'b1;
						end
					end else if (in_item.byte_present && fill_q == 6'd63) begin
						st_q    <= ST_COMP;
						final_q <= 1'b0;
					end
				end
			end
			ST_PAD: begin
				pad_q <= pad_q + 6'd1;
				if (pad_q == 6'd63) begin
					st_q <= ST_COMP;
				end
			end
			ST_COMP: begin
				if (done) begin
					if (extra_q && !final_q) begin
						// padding-only block: 0x80 at 0 when fill wrapped
						extra_q <= 1'b0;
						final_q <= 1'b1;
						pad_q   <= '0;
						st_q    <= ST_PAD;
					end else if (final_q && !pass2_q && !extra_q && fill_q >= 6'd56) begin
						// 0x80 did not leave room for the length: length-only block
						extra_q <= 1'b1;
						pad_q   <= '0;
						st_q    <= ST_PAD;
					end else if (final_q && !pass2_q) begin
						extra_q <= 1'b0;
						pass2_q <= key_ready_q;
						pad_q   <= '0;
						st_q    <= key_ready_q ? ST_PAD : ST_OUT2;
						fill_q  <= '0;
					end else if (pass2_q) begin
						st_q <= ST_OUT1;
					end else begin
						st_q <= ST_IDLE;
					end
				end
			end
			ST_OUT1: st_q <= ST_OUT2;
			ST_OUT2: begin
				st_q    <= ST_IDLE;
				pass2_q <= 1'b0;
				final_q <= 1'b0;
				fresh_q <= 1'b1;
				bits_q  <= '0;
				fill_q  <= '0;
			end
			default: st_q <= ST_IDLE;
			endcase
			if (cmd.go && !pass2_q) begin
				fresh_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_COMP && done && !pass2_q) begin
			digest_q <= chain;
		end
	end

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			outer[127-8*i -: 8] = chain[8*i +: 8];
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_OUT1) begin
			half2_q <= outer[63:0];
		end
	end

	always_comb begin
		out_strobe = 1'b0;
		out_item   = '0;
		if (st_q == ST_OUT1) begin
			out_strobe            = 1'b1;
			out_item.digest_half  = outer[127:64];
			out_item.digest_valid = 1'b1;
		end else if (st_q == ST_OUT2) begin
			out_strobe            = 1'b1;
			out_item.digest_half  = pass2_q ? half2_q : 64'd0;
			out_item.digest_valid = pass2_q;
			out_item.last_half    = 1'b1;
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe |-> busy) else $error("result outside busy window");
	a_out_order: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT1) |=> (st_q == ST_OUT2)) else $error("second half lost");
	a_pad_to_comp: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_PAD && pad_q == 6'd63) |=> (st_q == ST_COMP))
		else $error("padding did not start compression");
endmodule
`default_nettype wire
